>>> hw/rtl/assert_macros.svh
// Assertion helpers; expect clk and arst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define KC_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("check failed");

`define KC_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("check failed");

`endif

>>> hw/rtl/kc3n_pkg.sv
package kc3n_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COEF_BITS  = 8;

	localparam int DIM_W  = 11;
	localparam int AW     = $clog2(MAX_WIDTH);
	localparam int PIX_W  = 8;
	localparam int OUT_W  = 20;
	localparam int SUM_W  = PIX_W + COEF_BITS + 4;
	localparam int TOT_W  = COEF_BITS + 4;
	localparam int EXT_W  = (SUM_W > OUT_W) ? SUM_W : OUT_W;
	localparam int DCNT_W = $clog2(SUM_W);
	localparam int CREG_W = 3 * COEF_BITS;

	localparam logic [2:0] REG_COEF_M = 3'd0;
	localparam logic [2:0] REG_COEF_Z = 3'd1;
	localparam logic [2:0] REG_COEF_P = 3'd2;
	localparam logic [2:0] REG_WIDTH  = 3'd3;
	localparam logic [2:0] REG_HEIGHT = 3'd4;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             is_padding;
	} pix_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] filtered_value;
		logic                    was_divided;
		logic                    end_of_frame;
	} res_t;

	typedef struct packed {
		logic [2:0][2:0][COEF_BITS-1:0] coef;
		logic [DIM_W-1:0]               width;
		logic [DIM_W-1:0]               height;
	} cfg_t;

	typedef struct packed {
		logic [8:0][PIX_W-1:0] pix;
		logic [8:0]            mask;
		logic                  eof;
	} job_t;

	typedef enum logic {F_IDLE, F_UPD} front_state_t;

	typedef enum logic [2:0] {B_IDLE, B_MAC, B_PREP, B_DIV, B_FIN, B_OUT} back_state_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] maxv);
		logic [DIM_W-1:0] r;
		if (v == '0)
			r = DIM_W'(1);
		else if (v > maxv)
			r = maxv;
		else
			r = v;
		return r;
	endfunction

	function automatic logic signed [OUT_W-1:0] saturate(input logic signed [SUM_W-1:0] v);
		logic signed [EXT_W-1:0] ve;
		logic signed [EXT_W-1:0] vmax;
		logic signed [EXT_W-1:0] vmin;
		logic signed [OUT_W-1:0] r;
		ve   = EXT_W'(v);
		vmax = EXT_W'({1'b0, {(OUT_W-1){1'b1}}});
		vmin = EXT_W'({1'b1, {(OUT_W-1){1'b0}}});
		if (ve > vmax)
			r = {1'b0, {(OUT_W-1){1'b1}}};
		else if (ve < vmin)
			r = {1'b1, {(OUT_W-1){1'b0}}};
		else
			r = ve[OUT_W-1:0];
		return r;
	endfunction

endpackage

>>> hw/rtl/kc3n_front.sv
module kc3n_front (
	input  logic            clk,
	input  logic            arst_n,
	input  kc3n_pkg::cfg_t  cfg,
	input  logic            pix_valid,
	output logic            pix_ready,
	input  kc3n_pkg::pix_t  pix_data,
	input  logic            q_full,
	output logic            push,
	output kc3n_pkg::job_t  job
);

	kc3n_pkg::front_state_t state_q, state_d;

	logic [kc3n_pkg::PIX_W-1:0] mem_upper_q [kc3n_pkg::MAX_WIDTH];
	logic [kc3n_pkg::PIX_W-1:0] mem_middle_q [kc3n_pkg::MAX_WIDTH];
	logic [kc3n_pkg::PIX_W-1:0] top_rd_q, mid_rd_q, p_q;
	logic [8:0][kc3n_pkg::PIX_W-1:0] win_q, win_n;
	logic [kc3n_pkg::DIM_W-1:0] col_q, row_q, ocol_q, orow_q;
	logic [kc3n_pkg::DIM_W-1:0] w, h;
	logic [kc3n_pkg::DIM_W:0] col_inc, ocol_inc, orow_inc;
	logic accept, upd, emit, in_wrap, out_wrap, eof;
	logic [2:0] cv, rv;

	assign w = kc3n_pkg::clamp_dim(cfg.width, kc3n_pkg::DIM_W'(kc3n_pkg::MAX_WIDTH));
	assign h = kc3n_pkg::clamp_dim(cfg.height, kc3n_pkg::DIM_W'(kc3n_pkg::MAX_HEIGHT));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kc3n_pkg::F_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pix_ready = 1'b0;
		upd       = 1'b0;
		unique case (state_q)
			kc3n_pkg::F_IDLE: begin
				pix_ready = !q_full;
				if (pix_valid && !q_full)
					state_d = kc3n_pkg::F_UPD;
			end
			kc3n_pkg::F_UPD: begin
				upd     = 1'b1;
				state_d = kc3n_pkg::F_IDLE;
			end
			default: state_d = kc3n_pkg::F_IDLE;
		endcase
	end

	assign accept = pix_valid && pix_ready;

	always_ff @(posedge clk) begin
		if (accept) begin
			top_rd_q <= mem_upper_q[col_q[kc3n_pkg::AW-1:0]];
			mid_rd_q <= mem_middle_q[col_q[kc3n_pkg::AW-1:0]];
			p_q      <= pix_data.is_padding ? '0 : pix_data.pixel;
		end
		if (upd) begin
			mem_upper_q[col_q[kc3n_pkg::AW-1:0]]  <= mid_rd_q;
			mem_middle_q[col_q[kc3n_pkg::AW-1:0]] <= p_q;
		end
	end

	always_comb begin
		for (int k = 0; k < 6; k++)
			win_n[k] = win_q[k+3];
		win_n[6] = top_rd_q;
		win_n[7] = mid_rd_q;
		win_n[8] = p_q;
	end

	assign col_inc  = {1'b0, col_q} + 1'b1;
	assign ocol_inc = {1'b0, ocol_q} + 1'b1;
	assign orow_inc = {1'b0, orow_q} + 1'b1;
	assign in_wrap  = col_inc >= {1'b0, w};
	assign out_wrap = ocol_inc >= {1'b0, w};
	assign eof      = out_wrap && (orow_inc >= {1'b0, h});
	assign emit     = (row_q >= kc3n_pkg::DIM_W'(2)) ||
		(row_q == kc3n_pkg::DIM_W'(1) && col_q != '0);

	assign cv[0] = (ocol_q != '0) && (ocol_q <= w);
	assign cv[1] = ocol_q < w;
	assign cv[2] = ocol_inc < {1'b0, w};
	assign rv[0] = (orow_q != '0) && (orow_q <= h);
	assign rv[1] = orow_q < h;
	assign rv[2] = orow_inc < {1'b0, h};

	always_comb begin
		job.pix = win_n;
		job.eof = eof;
		for (int c = 0; c < 3; c++)
			for (int r = 0; r < 3; r++)
				job.mask[c*3+r] = cv[c] & rv[r];
	end

	assign push = upd && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q  <= '0;
			col_q  <= '0;
			row_q  <= '0;
			ocol_q <= '0;
			orow_q <= '0;
		end else if (upd) begin
			win_q <= win_n;
			if (emit && eof) begin
				col_q  <= '0;
				row_q  <= '0;
				ocol_q <= '0;
				orow_q <= '0;
			end else begin
				if (in_wrap) begin
					col_q <= '0;
					if (row_q != '1)
						row_q <= row_q + 1'b1;
				end else begin
					col_q <= col_inc[kc3n_pkg::DIM_W-1:0];
				end
				if (emit) begin
					if (out_wrap) begin
						ocol_q <= '0;
						orow_q <= orow_inc[kc3n_pkg::DIM_W-1:0];
					end else begin
						ocol_q <= ocol_inc[kc3n_pkg::DIM_W-1:0];
					end
				end
			end
		end
	end

endmodule

>>> hw/rtl/kc3n_queue.sv
module kc3n_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  kc3n_pkg::job_t wr_data,
	input  logic           pop,
	output kc3n_pkg::job_t rd_data,
	output logic           full,
	output logic           empty
);

	kc3n_pkg::job_t mem_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign full    = cnt_q == 2'd2;
	assign empty   = cnt_q == 2'd0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= !wr_ptr_q;
			if (pop)
				rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

>>> hw/rtl/kc3n_back.sv
module kc3n_back (
	input  logic           clk,
	input  logic           arst_n,
	input  kc3n_pkg::cfg_t cfg,
	input  logic           q_empty,
	input  kc3n_pkg::job_t job,
	output logic           pop,
	output logic           res_valid,
	input  logic           res_ready,
	output kc3n_pkg::res_t res_data
);

	kc3n_pkg::back_state_t state_q, state_d;

	logic [8:0][kc3n_pkg::PIX_W-1:0] pix_q;
	logic [8:0] mask_q;
	logic eof_q, neg_q;
	logic [1:0] col_q, row_q;
	logic signed [kc3n_pkg::SUM_W-1:0] sum_q, prod, quo_s;
	logic signed [kc3n_pkg::TOT_W-1:0] tot_q;
	logic signed [kc3n_pkg::COEF_BITS-1:0] coef;
	logic [kc3n_pkg::SUM_W-1:0] quo_q, quo_n;
	logic [kc3n_pkg::TOT_W-1:0] div_q;
	logic [kc3n_pkg::TOT_W:0] rem_q, rem_sh, rem_n;
	logic [kc3n_pkg::DCNT_W-1:0] dcnt_q;
	logic ge, mac_last, div_last;
	kc3n_pkg::res_t res_q;

	assign coef     = cfg.coef[col_q][row_q];
	assign prod     = $signed({1'b0, pix_q[0]}) * coef;
	assign mac_last = col_q == 2'd2 && row_q == 2'd2;
	assign div_last = dcnt_q == kc3n_pkg::DCNT_W'(kc3n_pkg::SUM_W - 1);

	assign rem_sh = {rem_q[kc3n_pkg::TOT_W-1:0], quo_q[kc3n_pkg::SUM_W-1]};
	assign ge     = rem_sh >= {1'b0, div_q};
	assign rem_n  = ge ? rem_sh - {1'b0, div_q} : rem_sh;
	assign quo_n  = {quo_q[kc3n_pkg::SUM_W-2:0], ge};
	assign quo_s  = neg_q ? -$signed(quo_q) : $signed(quo_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kc3n_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		pop       = 1'b0;
		res_valid = 1'b0;
		unique case (state_q)
			kc3n_pkg::B_IDLE: begin
				if (!q_empty) begin
					pop     = 1'b1;
					state_d = kc3n_pkg::B_MAC;
				end
			end
			kc3n_pkg::B_MAC: begin
				if (mac_last)
					state_d = kc3n_pkg::B_PREP;
			end
			kc3n_pkg::B_PREP: begin
				state_d = (tot_q == '0) ? kc3n_pkg::B_OUT : kc3n_pkg::B_DIV;
			end
			kc3n_pkg::B_DIV: begin
				if (div_last)
					state_d = kc3n_pkg::B_FIN;
			end
			kc3n_pkg::B_FIN: state_d = kc3n_pkg::B_OUT;
			kc3n_pkg::B_OUT: begin
				res_valid = 1'b1;
				if (res_ready)
					state_d = kc3n_pkg::B_IDLE;
			end
			default: state_d = kc3n_pkg::B_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		case (state_q)
			kc3n_pkg::B_IDLE: begin
				pix_q  <= job.pix;
				mask_q <= job.mask;
				eof_q  <= job.eof;
				col_q  <= '0;
				row_q  <= '0;
				sum_q  <= '0;
				tot_q  <= '0;
			end
			kc3n_pkg::B_MAC: begin
				if (mask_q[0]) begin
					sum_q <= sum_q + prod;
					tot_q <= tot_q + kc3n_pkg::TOT_W'(coef);
				end
				pix_q  <= {kc3n_pkg::PIX_W'(0), pix_q[8:1]};
				mask_q <= {1'b0, mask_q[8:1]};
				if (row_q == 2'd2) begin
					row_q <= '0;
					col_q <= col_q + 1'b1;
				end else begin
					row_q <= row_q + 1'b1;
				end
			end
			kc3n_pkg::B_PREP: begin
				quo_q  <= sum_q[kc3n_pkg::SUM_W-1] ? kc3n_pkg::SUM_W'(-sum_q) : sum_q;
				div_q  <= tot_q[kc3n_pkg::TOT_W-1] ? kc3n_pkg::TOT_W'(-tot_q) : tot_q;
				neg_q  <= sum_q[kc3n_pkg::SUM_W-1] ^ tot_q[kc3n_pkg::TOT_W-1];
				rem_q  <= '0;
				dcnt_q <= '0;
				res_q.filtered_value <= kc3n_pkg::saturate(sum_q);
				res_q.was_divided    <= 1'b0;
				res_q.end_of_frame   <= eof_q;
			end
			kc3n_pkg::B_DIV: begin
				quo_q  <= quo_n;
				rem_q  <= rem_n;
				dcnt_q <= dcnt_q + 1'b1;
			end
			kc3n_pkg::B_FIN: begin
				res_q.filtered_value <= kc3n_pkg::saturate(quo_s);
				res_q.was_divided    <= 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign res_data = res_q;

endmodule

>>> hw/rtl/kernel_conv3x3_normalized.sv
// Path: line store update and queue write, queue read, MAC over the nine taps, setup, divide,
// finish; divide and finish are skipped when the coefficient total is zero.
// Results trail the input by one row and one pixel.
// Flow: the front takes pixels while the queue has room, and not again until its update is
// done; the back end takes one job at a time and divides one quotient bit per cycle.
// Reset: arst_n clears control, counters and window, loads 1024x1024; line stores keep data.
`include "assert_macros.svh"

module kernel_conv3x3_normalized (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [4:0]     paddr,
	input  logic [31:0]    pwdata,
	output logic [31:0]    prdata,
	output logic           pready,
	input  logic           pix_valid,
	output logic           pix_ready,
	input  kc3n_pkg::pix_t pix_data,
	output logic           res_valid,
	input  logic           res_ready,
	output kc3n_pkg::res_t res_data
);

	logic [kc3n_pkg::CREG_W-1:0] coef_q [3];
	logic [kc3n_pkg::DIM_W-1:0] width_q, height_q;
	logic [2:0] idx;
	logic wr_en, q_push, q_pop, q_full, q_empty;
	kc3n_pkg::cfg_t cfg;
	kc3n_pkg::job_t q_wr, q_rd;

	assign pready = 1'b1;
	assign idx    = paddr[4:2];
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q[0] <= '0;
			coef_q[1] <= '0;
			coef_q[2] <= '0;
			width_q   <= kc3n_pkg::DIM_W'(1024);
			height_q  <= kc3n_pkg::DIM_W'(1024);
		end else if (wr_en) begin
			unique case (idx)
				kc3n_pkg::REG_COEF_M: coef_q[0] <= pwdata[kc3n_pkg::CREG_W-1:0];
				kc3n_pkg::REG_COEF_Z: coef_q[1] <= pwdata[kc3n_pkg::CREG_W-1:0];
				kc3n_pkg::REG_COEF_P: coef_q[2] <= pwdata[kc3n_pkg::CREG_W-1:0];
				kc3n_pkg::REG_WIDTH:  width_q   <= pwdata[kc3n_pkg::DIM_W-1:0];
				kc3n_pkg::REG_HEIGHT: height_q  <= pwdata[kc3n_pkg::DIM_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			kc3n_pkg::REG_COEF_M: prdata = 32'(coef_q[0]);
			kc3n_pkg::REG_COEF_Z: prdata = 32'(coef_q[1]);
			kc3n_pkg::REG_COEF_P: prdata = 32'(coef_q[2]);
			kc3n_pkg::REG_WIDTH:  prdata = 32'(width_q);
			kc3n_pkg::REG_HEIGHT: prdata = 32'(height_q);
			default:              prdata = '0;
		endcase
	end

	always_comb begin
		cfg.coef[0] = coef_q[0];
		cfg.coef[1] = coef_q[1];
		cfg.coef[2] = coef_q[2];
		cfg.width   = width_q;
		cfg.height  = height_q;
	end

	kc3n_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix_data  (pix_data),
		.q_full    (q_full),
		.push      (q_push),
		.job       (q_wr)
	);

	kc3n_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.wr_data (q_wr),
		.pop     (q_pop),
		.rd_data (q_rd),
		.full    (q_full),
		.empty   (q_empty)
	);

	kc3n_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_empty   (q_empty),
		.job       (q_rd),
		.pop       (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	`KC_ASSERT_SAME(a_no_overflow, q_push, !q_full || q_pop)
	`KC_ASSERT_SAME(a_no_underflow, q_pop, !q_empty)
	`KC_ASSERT_NEXT(a_accept_then_busy, pix_valid && pix_ready, !pix_ready)

endmodule

>>> tb/kernel_conv3x3_normalized_tb.sv
module kernel_conv3x3_normalized_tb;
	timeunit 1ns;
	timeprecision 1ps;

	class conv_scoreboard;
		logic [kc3n_pkg::CREG_W-1:0] coef_reg [3];
		logic [kc3n_pkg::DIM_W-1:0] width_reg, height_reg;
		logic [kc3n_pkg::PIX_W-1:0] upper_line [kc3n_pkg::MAX_WIDTH];
		logic [kc3n_pkg::PIX_W-1:0] middle_line [kc3n_pkg::MAX_WIDTH];
		logic [kc3n_pkg::PIX_W-1:0] win [9];
		int unsigned in_col, in_row, out_col, out_row;
		kc3n_pkg::res_t pending_res [$];
		int errors;

		function new();
			for (int i = 0; i < 3; i++)
				coef_reg[i] = '0;
			width_reg = 11'd1024;
			height_reg = 11'd1024;
			for (int i = 0; i < kc3n_pkg::MAX_WIDTH; i++) begin
				upper_line[i] = '0;
				middle_line[i] = '0;
			end
			for (int i = 0; i < 9; i++)
				win[i] = '0;
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
			errors = 0;
		endfunction

		function int unsigned dim(logic [kc3n_pkg::DIM_W-1:0] v, int unsigned maxv);
			if (v == 0)
				return 1;
			if (v > maxv)
				return maxv;
			return v;
		endfunction

		function int coef(int col, int row);
			logic signed [kc3n_pkg::COEF_BITS-1:0] f;
			f = coef_reg[col][row*kc3n_pkg::COEF_BITS +: kc3n_pkg::COEF_BITS];
			return f;
		endfunction

		function void note_pixel(kc3n_pkg::pix_t it);
			int unsigned w, h;
			logic [kc3n_pkg::PIX_W-1:0] p, top, mid;
			bit emit, eof;
			int sum, total, val, nx, ny, c;
			kc3n_pkg::res_t r;
			w = dim(width_reg, kc3n_pkg::MAX_WIDTH);
			h = dim(height_reg, kc3n_pkg::MAX_HEIGHT);
			p = it.is_padding ? '0 : it.pixel;
			top = '0;
			mid = '0;
			emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
			if (in_col < kc3n_pkg::MAX_WIDTH) begin
				top = upper_line[in_col];
				mid = middle_line[in_col];
				upper_line[in_col] = mid;
				middle_line[in_col] = p;
			end
			for (int k = 0; k < 6; k++)
				win[k] = win[k+3];
			win[6] = top;
			win[7] = mid;
			win[8] = p;
			if (in_col + 1 >= w) begin
				in_col = 0;
				if (in_row < 2047)
					in_row++;
			end else begin
				in_col++;
			end
			if (!emit)
				return;
			sum = 0;
			total = 0;
			for (int col = 0; col < 3; col++)
				for (int row = 0; row < 3; row++) begin
					nx = int'(out_col) + col - 1;
					ny = int'(out_row) + row - 1;
					if (nx >= 0 && nx < int'(w) && ny >= 0 && ny < int'(h)) begin
						c = coef(col, row);
						sum += int'(win[col*3+row]) * c;
						total += c;
					end
				end
			val = (total != 0) ? sum / total : sum;
			if (val > 524287)
				val = 524287;
			if (val < -524288)
				val = -524288;
			eof = 0;
			if (out_col + 1 >= w) begin
				out_col = 0;
				if (out_row + 1 >= h)
					eof = 1;
				else
					out_row++;
			end else begin
				out_col++;
			end
			if (eof) begin
				in_col = 0;
				in_row = 0;
				out_col = 0;
				out_row = 0;
			end
			r.filtered_value = val[kc3n_pkg::OUT_W-1:0];
			r.was_divided = (total != 0);
			r.end_of_frame = eof;
			pending_res = {pending_res, r};
		endfunction

		function void check_result(kc3n_pkg::res_t got);
			kc3n_pkg::res_t e;
			if (pending_res.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			e = pending_res.pop_front();
			if (got.filtered_value !== e.filtered_value) begin
				$display("%0t: filtered_value exp %0d got %0d", $time,
					e.filtered_value, got.filtered_value);
				errors++;
			end
			if (got.was_divided !== e.was_divided) begin
				$display("%0t: was_divided exp %b got %b", $time, e.was_divided,
					got.was_divided);
				errors++;
			end
			if (got.end_of_frame !== e.end_of_frame) begin
				$display("%0t: end_of_frame exp %b got %b", $time, e.end_of_frame,
					got.end_of_frame);
				errors++;
			end
		endfunction
	endclass

	logic clk, arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;
	logic pready;
	logic pix_valid, pix_ready, res_valid, res_ready;
	kc3n_pkg::pix_t pix_data;
	kc3n_pkg::res_t res_data;

	conv_scoreboard sb;
	int send_idle_pct, recv_stall_pct;
	int hold_off_cycles;

	kernel_conv3x3_normalized dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.pix_valid(pix_valid), .pix_ready(pix_ready), .pix_data(pix_data),
		.res_valid(res_valid), .res_ready(res_ready), .res_data(res_data)
	);

	initial begin
		clk = 0;
		forever #2 clk = ~clk;
	end

	initial begin
		#20ms;
		$display("[kernel_conv3x3_normalized] ERROR");
		$finish;
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		paddr = {idx, 2'b00};
		pwdata = val;
		pwrite = 1;
		psel = 1;
		penable = 0;
		@(negedge clk);
		penable = 1;
		@(negedge clk);
		psel = 0;
		penable = 0;
		pwrite = 0;
		case (idx)
			kc3n_pkg::REG_COEF_M, kc3n_pkg::REG_COEF_Z, kc3n_pkg::REG_COEF_P:
				sb.coef_reg[idx] = val[kc3n_pkg::CREG_W-1:0];
			kc3n_pkg::REG_WIDTH: sb.width_reg = val[kc3n_pkg::DIM_W-1:0];
			kc3n_pkg::REG_HEIGHT: sb.height_reg = val[kc3n_pkg::DIM_W-1:0];
			default: ;
		endcase
	endtask

	task automatic send_pixel(logic [7:0] p, logic pad);
		while ($urandom_range(99) < send_idle_pct) begin
			pix_valid <= 0;
			@(negedge clk);
		end
		pix_valid <= 1;
		pix_data <= '{pixel: p, is_padding: pad};
		@(posedge clk);
		while (!pix_ready)
			@(posedge clk);
		sb.note_pixel('{pixel: p, is_padding: pad});
		@(negedge clk);
	endtask

	task automatic drain();
		pix_valid <= 0;
		while (sb.pending_res.size() != 0)
			@(negedge clk);
		repeat (60) @(negedge clk);
	endtask

	task automatic set_coefs(logic [23:0] m, logic [23:0] z, logic [23:0] p);
		reg_write(kc3n_pkg::REG_COEF_M, {8'd0, m});
		reg_write(kc3n_pkg::REG_COEF_Z, {8'd0, z});
		reg_write(kc3n_pkg::REG_COEF_P, {8'd0, p});
	endtask

	task automatic run_frame(int w, int h, int mode);
		int unsigned px;
		int cw, ch;
		cw = (w == 0) ? 1 : w;
		ch = (h == 0) ? 1 : h;
		reg_write(kc3n_pkg::REG_WIDTH, w);
		reg_write(kc3n_pkg::REG_HEIGHT, h);
		for (int i = 0; i < cw * ch; i++) begin
			case (mode)
				0: px = 0;
				1: px = 255;
				default: px = $urandom_range(255);
			endcase
			send_pixel(px[7:0], (mode == 2) && ($urandom_range(19) == 0));
		end
		for (int i = 0; i <= cw; i++)
			send_pixel(8'($urandom_range(255)), 1'b1);
		drain();
	endtask

	always @(posedge clk)
		if (arst_n && res_valid && res_ready)
			sb.check_result(res_data);

	always @(negedge clk) begin
		if (hold_off_cycles > 0) begin
			hold_off_cycles <= hold_off_cycles - 1;
			res_ready <= 0;
		end else begin
			res_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		sb = new();
		arst_n = 0;
		psel = 0;
		penable = 0;
		pwrite = 0;
		paddr = '0;
		pwdata = '0;
		pix_valid = 0;
		pix_data = '0;
		res_ready = 0;
		hold_off_cycles = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		repeat (3) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		set_coefs(24'h010101, 24'h010401, 24'h010101);
		run_frame(3, 3, 1);
		set_coefs(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F);
		run_frame(1, 1, 0);
		set_coefs(24'h808080, 24'h808080, 24'h808080);
		run_frame(4, 2, 1);
		set_coefs(24'h00FF01, 24'h000000, 24'h0001FF);
		run_frame(3, 2, 2);
		set_coefs(24'h000000, 24'h000000, 24'h000000);
		run_frame(0, 3, 1);

		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 1) ? 88 : 29) : 0;
			recv_stall_pct = (ph == 2) ? 88 : ((ph == 3) ? 29 : 0);
			if (ph == 0)
				hold_off_cycles = 400;
			for (int f = 0; f < 3; f++) begin
				set_coefs(24'($urandom), 24'($urandom), 24'($urandom));
				run_frame($urandom_range(1, 12), $urandom_range(1, 8), 2);
			end
		end
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_coefs(24'h010101, 24'h010101, 24'h010101);
		run_frame(160, 1, 2);
		set_coefs(24'($urandom), 24'($urandom), 24'($urandom));
		run_frame(2, 40, 2);

		if (sb.errors == 0)
			$display("[kernel_conv3x3_normalized] OK");
		else
			$display("[kernel_conv3x3_normalized] ERROR");
		$finish;
	end

endmodule
